>>> rtl/core/wpd_pkg.sv
// shared types, codes and constants of the wave pcm stream decoder
package wpd_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_CHUNK,
		PH_FMT,
		PH_SKIP,
		PH_DATA,
		PH_DONE,
		PH_ERROR
	} phase_t;

	// input word kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// result kinds
	localparam logic [1:0] RES_FRAME     = 2'd0;
	localparam logic [1:0] RES_FORMAT    = 2'd1;
	localparam logic [1:0] RES_ERROR     = 2'd2;
	localparam logic [1:0] RES_EARLY_END = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NOT_WAV     = 2'd0;
	localparam logic [1:0] ERR_COMPRESSED  = 2'd1;
	localparam logic [1:0] ERR_NO_AUDIO    = 2'd2;
	localparam logic [1:0] ERR_UNSUPPORTED = 2'd3;

	// chunk tags, big-endian as they arrive, and fmt format tags
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;
	localparam logic [15:0] TAG_EXT  = 16'hFFFE;
	localparam logic [15:0] TAG_PCM  = 16'h0001;

	// header layout
	localparam int HDR_RIFF_LEN  = 4;
	localparam int HDR_LEN       = 12;
	localparam int CHUNK_HDR_LEN = 8;

	// fmt body layout
	localparam logic [5:0] FMT_TAKE      = 6'd40;
	localparam logic [5:0] FMT_TAG_LO    = 6'd0;
	localparam logic [5:0] FMT_TAG_HI    = 6'd1;
	localparam logic [5:0] FMT_CHAN_LO   = 6'd2;
	localparam logic [5:0] FMT_CHAN_HI   = 6'd3;
	localparam logic [5:0] FMT_RATE_0    = 6'd4;
	localparam logic [5:0] FMT_RATE_1    = 6'd5;
	localparam logic [5:0] FMT_RATE_2    = 6'd6;
	localparam logic [5:0] FMT_RATE_3    = 6'd7;
	localparam logic [5:0] FMT_BITS_LO   = 6'd14;
	localparam logic [5:0] FMT_BITS_HI   = 6'd15;
	localparam logic [5:0] FMT_EXT_LO    = 6'd24;
	localparam logic [5:0] FMT_EXT_HI    = 6'd25;
	localparam logic [31:0] FMT_EXT_MIN  = 32'd26;

	// accepted format range
	localparam logic [31:0] RATE_MIN  = 32'd8000;
	localparam logic [31:0] RATE_MAX  = 32'd48000;
	localparam logic [7:0]  U8_OFFSET = 8'h80;

	// input word
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
	} in_item_t;

	// result word
	typedef struct packed {
		logic [1:0]         result_kind;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [1:0]         channels;
		logic [15:0]        sample_rate;
		logic [5:0]         sample_bits;
		logic [1:0]         error_code;
		logic               audio_done;
	} result_t;

	// frame buffer control from the parser
	typedef struct packed {
		logic       wr;
		logic [2:0] idx;
		logic [7:0] data;
		logic [2:0] bps;
		logic       stereo;
	} frame_ctl_t;

endpackage

>>> rtl/core/wpd_stream_if.sv
// valid/ready stream channel carrying one word per handshake
interface wpd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/wpd_frame.sv
// frame byte buffer and 16-bit sample conversion
module wpd_frame (
	input  logic                  clk,
	input  logic                  en,
	input  wpd_pkg::frame_ctl_t   ctl,
	output logic signed [15:0]    left_sample,
	output logic signed [15:0]    right_sample
);

	logic [7:0] fbuf_q [8];
	logic [7:0] eff [8];
	logic signed [15:0] left_c;
	logic signed [15:0] right_c;

	// byte store, no reset: only bytes of the current frame are read
	always_ff @(posedge clk) begin
		if (en && ctl.wr) begin
			fbuf_q[ctl.idx] <= ctl.data;
		end
	end

	// frame view with the incoming byte already in place
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			eff[i] = (ctl.wr && (ctl.idx == 3'(i))) ? ctl.data : fbuf_q[i];
		end
	end

	// take the top two bytes of each sample, 8-bit samples re-centred
	always_comb begin
		left_c  = '0;
		right_c = '0;
		case (ctl.bps)
			3'd1: begin
				left_c  = {eff[0] ^ wpd_pkg::U8_OFFSET, 8'h00};
				right_c = {eff[1] ^ wpd_pkg::U8_OFFSET, 8'h00};
			end
			3'd2: begin
				left_c  = {eff[1], eff[0]};
				right_c = {eff[3], eff[2]};
			end
			3'd3: begin
				left_c  = {eff[2], eff[1]};
				right_c = {eff[5], eff[4]};
			end
			default: begin
				left_c  = {eff[3], eff[2]};
				right_c = {eff[7], eff[6]};
			end
		endcase
	end

	assign left_sample  = left_c;
	assign right_sample = ctl.stereo ? right_c : left_c;

endmodule

>>> rtl/core/wpd_parser.sv
// riff/wave header and chunk parser with at most one result per input word
module wpd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  wpd_pkg::in_item_t  item,
	output logic               res_valid,
	output wpd_pkg::result_t   res
);

	wpd_pkg::phase_t phase_q, phase_n;
	logic [32:0] count_q, count_n;
	logic [31:0] id_q, id_n;
	logic [31:0] len_q, len_n;
	logic [15:0] fmt_tag_q, fmt_tag_n;
	logic [15:0] ext_tag_q, ext_tag_n;
	logic [15:0] chan_q, chan_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] bits_q, bits_n;
	logic        fmt_seen_q, fmt_seen_n;
	logic [31:0] left_q, left_n;
	logic [2:0]  fbi_q, fbi_n;

	logic        is_byte, is_start, is_end;
	logic [7:0]  b;
	logic [32:0] count_inc;
	logic [31:0] id_shift;
	logic [31:0] len_merge;
	logic        chunk_last;
	logic [32:0] skip_len;

	logic [15:0] fmt_tag_f, ext_tag_f, chan_f, bits_f;
	logic [31:0] rate_f;
	logic [5:0]  take;
	logic        fmt_last;
	logic        fmt_pcm;
	logic [32:0] fmt_rest;
	logic        fmt_ok;

	logic [2:0]  bps;
	logic        stereo;
	logic [3:0]  frame_len;
	logic [3:0]  fbi_inc;
	logic        frame_more;
	logic [31:0] left_dec;
	logic        data_last;

	logic        fail;
	logic [1:0]  fail_code;
	logic        give_fmt, give_frame, give_end;

	wpd_pkg::frame_ctl_t frame_ctl;
	logic signed [15:0]  left_s, right_s;

	// input decode
	assign is_byte  = (item.kind == wpd_pkg::KIND_BYTE);
	assign is_start = (item.kind == wpd_pkg::KIND_START);
	assign is_end   = (item.kind == wpd_pkg::KIND_END);
	assign b        = item.byte_value;

	// header and chunk header assembly
	assign count_inc  = count_q + 33'd1;
	assign id_shift   = {id_q[23:0], b};
	assign len_merge  = len_q | ({24'd0, b} << {count_q[1:0], 3'b000});
	assign chunk_last = (count_inc == 33'(wpd_pkg::CHUNK_HDR_LEN));
	assign skip_len   = {1'b0, len_merge} + {32'd0, len_merge[0]};

	// fmt field capture at fixed byte offsets
	always_comb begin
		fmt_tag_f = fmt_tag_q;
		ext_tag_f = ext_tag_q;
		chan_f    = chan_q;
		rate_f    = rate_q;
		bits_f    = bits_q;
		case (count_q[5:0])
			wpd_pkg::FMT_TAG_LO:  fmt_tag_f = {8'd0, b};
			wpd_pkg::FMT_TAG_HI:  fmt_tag_f = {b, fmt_tag_q[7:0]};
			wpd_pkg::FMT_CHAN_LO: chan_f    = {8'd0, b};
			wpd_pkg::FMT_CHAN_HI: chan_f    = {b, chan_q[7:0]};
			wpd_pkg::FMT_RATE_0,
			wpd_pkg::FMT_RATE_1,
			wpd_pkg::FMT_RATE_2,
			wpd_pkg::FMT_RATE_3:  rate_f    = rate_q | ({24'd0, b} << {count_q[1:0], 3'b000});
			wpd_pkg::FMT_BITS_LO: bits_f    = {8'd0, b};
			wpd_pkg::FMT_BITS_HI: bits_f    = {b, bits_q[7:0]};
			wpd_pkg::FMT_EXT_LO:  ext_tag_f = {8'd0, b};
			wpd_pkg::FMT_EXT_HI:  ext_tag_f = {b, ext_tag_q[7:0]};
			default: ;
		endcase
	end

	// end of fmt body and pcm check
	assign take     = (len_q < {26'd0, wpd_pkg::FMT_TAKE}) ? len_q[5:0] : wpd_pkg::FMT_TAKE;
	assign fmt_last = (count_inc[5:0] == take);
	assign fmt_pcm  = (((fmt_tag_f == wpd_pkg::TAG_EXT) && (len_q >= wpd_pkg::FMT_EXT_MIN))
	                   ? ext_tag_f : fmt_tag_f) == wpd_pkg::TAG_PCM;
	assign fmt_rest = {1'b0, len_q - {26'd0, take}} + {32'd0, len_q[0]};

	// format check for the data chunk
	assign fmt_ok = ((chan_q == 16'd1) || (chan_q == 16'd2)) &&
	                (rate_q >= wpd_pkg::RATE_MIN) && (rate_q <= wpd_pkg::RATE_MAX) &&
	                ((bits_q == 16'd8) || (bits_q == 16'd16) ||
	                 (bits_q == 16'd24) || (bits_q == 16'd32));

	// frame progress
	assign bps        = bits_q[5:3];
	assign stereo     = chan_q[1];
	assign frame_len  = stereo ? {bps, 1'b0} : {1'b0, bps};
	assign fbi_inc    = {1'b0, fbi_q} + 4'd1;
	assign frame_more = (fbi_inc < frame_len);
	assign left_dec   = left_q - 32'd1;
	assign data_last  = (left_dec == 32'd0);

	// decisions for this word
	always_comb begin
		fail       = 1'b0;
		fail_code  = wpd_pkg::ERR_NOT_WAV;
		give_fmt   = 1'b0;
		give_frame = 1'b0;
		give_end   = 1'b0;
		if (is_byte) begin
			case (phase_q)
				wpd_pkg::PH_HEADER: begin
					if ((count_inc == 33'(wpd_pkg::HDR_RIFF_LEN)) &&
					    (id_shift != wpd_pkg::TAG_RIFF)) begin
						fail = 1'b1;
					end else if ((count_inc == 33'(wpd_pkg::HDR_LEN)) &&
					             (id_shift != wpd_pkg::TAG_WAVE)) begin
						fail = 1'b1;
					end
				end
				wpd_pkg::PH_CHUNK: begin
					if (chunk_last) begin
						if (id_q == wpd_pkg::TAG_FMT) begin
							// an empty fmt chunk leaves a zero tag
							if (len_merge == 32'd0) begin
								fail      = 1'b1;
								fail_code = wpd_pkg::ERR_COMPRESSED;
							end
						end else if (id_q == wpd_pkg::TAG_DATA) begin
							if (!fmt_seen_q) begin
								fail      = 1'b1;
								fail_code = wpd_pkg::ERR_NO_AUDIO;
							end else if (!fmt_ok) begin
								fail      = 1'b1;
								fail_code = wpd_pkg::ERR_UNSUPPORTED;
							end else begin
								give_fmt = 1'b1;
							end
						end
					end
				end
				wpd_pkg::PH_FMT: begin
					if (fmt_last && !fmt_pcm) begin
						fail      = 1'b1;
						fail_code = wpd_pkg::ERR_COMPRESSED;
					end
				end
				wpd_pkg::PH_DATA: begin
					give_frame = !frame_more;
				end
				default: ;
			endcase
		end else if (is_end) begin
			case (phase_q)
				wpd_pkg::PH_HEADER: begin
					fail = 1'b1;
				end
				wpd_pkg::PH_CHUNK, wpd_pkg::PH_FMT, wpd_pkg::PH_SKIP: begin
					fail      = 1'b1;
					fail_code = wpd_pkg::ERR_NO_AUDIO;
				end
				wpd_pkg::PH_DATA: begin
					give_end = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		phase_n    = phase_q;
		count_n    = count_q;
		id_n       = id_q;
		len_n      = len_q;
		fmt_tag_n  = fmt_tag_q;
		ext_tag_n  = ext_tag_q;
		chan_n     = chan_q;
		rate_n     = rate_q;
		bits_n     = bits_q;
		fmt_seen_n = fmt_seen_q;
		left_n     = left_q;
		fbi_n      = fbi_q;
		if (is_start) begin
			phase_n    = wpd_pkg::PH_HEADER;
			count_n    = '0;
			id_n       = '0;
			len_n      = '0;
			fmt_tag_n  = '0;
			ext_tag_n  = '0;
			chan_n     = '0;
			rate_n     = '0;
			bits_n     = '0;
			fmt_seen_n = 1'b0;
			left_n     = '0;
			fbi_n      = '0;
		end else if (fail) begin
			phase_n = wpd_pkg::PH_ERROR;
		end else if (is_byte) begin
			case (phase_q)
				wpd_pkg::PH_HEADER: begin
					id_n    = id_shift;
					count_n = count_inc;
					if (count_inc == 33'(wpd_pkg::HDR_LEN)) begin
						phase_n = wpd_pkg::PH_CHUNK;
						count_n = '0;
						id_n    = '0;
						len_n   = '0;
					end
				end
				wpd_pkg::PH_CHUNK: begin
					if (!count_q[2]) begin
						id_n = id_shift;
					end else begin
						len_n = len_merge;
					end
					count_n = count_inc;
					if (chunk_last) begin
						count_n = '0;
						if (id_q == wpd_pkg::TAG_FMT) begin
							fmt_tag_n = '0;
							ext_tag_n = '0;
							chan_n    = '0;
							rate_n    = '0;
							bits_n    = '0;
							phase_n   = wpd_pkg::PH_FMT;
						end else if (id_q == wpd_pkg::TAG_DATA) begin
							left_n  = len_merge;
							fbi_n   = '0;
							phase_n = (len_merge == 32'd0) ? wpd_pkg::PH_DONE
							                               : wpd_pkg::PH_DATA;
						end else begin
							// unknown chunk: skip body and pad byte
							count_n = skip_len;
							if (skip_len == 33'd0) begin
								id_n    = '0;
								len_n   = '0;
								phase_n = wpd_pkg::PH_CHUNK;
							end else begin
								phase_n = wpd_pkg::PH_SKIP;
							end
						end
					end
				end
				wpd_pkg::PH_FMT: begin
					fmt_tag_n = fmt_tag_f;
					ext_tag_n = ext_tag_f;
					chan_n    = chan_f;
					rate_n    = rate_f;
					bits_n    = bits_f;
					count_n   = count_inc;
					if (fmt_last) begin
						fmt_seen_n = 1'b1;
						count_n    = fmt_rest;
						if (fmt_rest == 33'd0) begin
							id_n    = '0;
							len_n   = '0;
							phase_n = wpd_pkg::PH_CHUNK;
						end else begin
							phase_n = wpd_pkg::PH_SKIP;
						end
					end
				end
				wpd_pkg::PH_SKIP: begin
					count_n = count_q - 33'd1;
					if (count_q == 33'd1) begin
						id_n    = '0;
						len_n   = '0;
						phase_n = wpd_pkg::PH_CHUNK;
					end
				end
				wpd_pkg::PH_DATA: begin
					left_n = left_dec;
					fbi_n  = frame_more ? fbi_inc[2:0] : 3'd0;
					if (data_last) begin
						phase_n = wpd_pkg::PH_DONE;
					end
				end
				default: ;
			endcase
		end else if (is_end && (phase_q == wpd_pkg::PH_DATA)) begin
			phase_n = wpd_pkg::PH_DONE;
			fbi_n   = '0;
		end
	end

	// result word
	always_comb begin
		res       = '0;
		res_valid = fail || give_fmt || give_frame || give_end;
		if (fail) begin
			res.result_kind = wpd_pkg::RES_ERROR;
			res.error_code  = fail_code;
		end else if (give_fmt) begin
			res.result_kind = wpd_pkg::RES_FORMAT;
			res.channels    = chan_q[1:0];
			res.sample_rate = rate_q[15:0];
			res.sample_bits = bits_q[5:0];
			res.audio_done  = (len_merge == 32'd0);
		end else if (give_frame) begin
			res.result_kind  = wpd_pkg::RES_FRAME;
			res.left_sample  = left_s;
			res.right_sample = right_s;
			res.audio_done   = data_last;
		end else if (give_end) begin
			res.result_kind = wpd_pkg::RES_EARLY_END;
		end
	end

	// frame buffer hookup
	assign frame_ctl.wr     = is_byte && (phase_q == wpd_pkg::PH_DATA);
	assign frame_ctl.idx    = fbi_q;
	assign frame_ctl.data   = b;
	assign frame_ctl.bps    = bps;
	assign frame_ctl.stereo = stereo;

	wpd_frame u_frame (
		.clk          (clk),
		.en           (en),
		.ctl          (frame_ctl),
		.left_sample  (left_s),
		.right_sample (right_s)
	);

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wpd_pkg::PH_IDLE;
			count_q    <= '0;
			id_q       <= '0;
			len_q      <= '0;
			fmt_tag_q  <= '0;
			ext_tag_q  <= '0;
			chan_q     <= '0;
			rate_q     <= '0;
			bits_q     <= '0;
			fmt_seen_q <= 1'b0;
			left_q     <= '0;
			fbi_q      <= '0;
		end else if (en) begin
			phase_q    <= phase_n;
			count_q    <= count_n;
			id_q       <= id_n;
			len_q      <= len_n;
			fmt_tag_q  <= fmt_tag_n;
			ext_tag_q  <= ext_tag_n;
			chan_q     <= chan_n;
			rate_q     <= rate_n;
			bits_q     <= bits_n;
			fmt_seen_q <= fmt_seen_n;
			left_q     <= left_n;
			fbi_q      <= fbi_n;
		end
	end

endmodule

>>> rtl/core/wav_pcm_stream_decoder_top.sv
// top level of the wave pcm stream decoder: input register, parser, result register
//
//   channel  direction  payload                      handshake
//   in_ch    sink       kind, byte_value             valid/ready
//   out_ch   source     result_kind .. audio_done    valid/ready
//
// one word is accepted every cycle unless a result waits; its result, if any,
// passes the input register, then the result register behind the parser.
// arst_n clears the parser to idle and empties both registers.
// while a result waits, one more word is taken into the input register; the
// input side then stalls until the result is taken.
module wav_pcm_stream_decoder_top (
	input  logic         clk,
	input  logic         arst_n,
	wpd_stream_if.sink   in_ch,
	wpd_stream_if.source out_ch
);

	logic               valid_s1;
	wpd_pkg::in_item_t  item_s1;
	logic               advance;
	logic               res_valid;
	wpd_pkg::result_t   res;
	logic               out_valid_q;
	wpd_pkg::result_t   result_q;

	// the parser moves when its result slot is free or being emptied
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= in_ch.payload;
		end
	end

	wpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			result_q <= res;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = result_q;

	// a format word carries a supported layout
	a_format_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_q.result_kind == wpd_pkg::RES_FORMAT)) |->
		((result_q.channels == 2'd1) || (result_q.channels == 2'd2)) &&
		(result_q.sample_rate >= 16'd8000) && (result_q.sample_rate <= 16'd48000) &&
		(result_q.error_code == wpd_pkg::ERR_NOT_WAV))
		else $error("format word outside supported layout");

	// format fields stay zero outside a format word
	a_format_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_q.result_kind != wpd_pkg::RES_FORMAT)) |->
		((result_q.channels == 2'd0) && (result_q.sample_rate == 16'd0) &&
		 (result_q.sample_bits == 6'd0)))
		else $error("format fields set outside a format word");

	// error words carry no samples and never end the audio
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_q.result_kind == wpd_pkg::RES_ERROR)) |->
		((result_q.left_sample == 16'sd0) && (result_q.right_sample == 16'sd0) &&
		 !result_q.audio_done))
		else $error("error word with sample data");

endmodule

>>> tb/wav_pcm_stream_decoder_top_tb.sv
// self-checking testbench of the wave pcm stream decoder top level
module wav_pcm_stream_decoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wpd_pkg::*;

	localparam int          HALF_PERIOD = 5;
	localparam int          WORD_TARGET = 1050;
	localparam int          LONG_HOLD   = 300;
	localparam int          TAIL_CYCLES = 16;
	localparam int          CYCLE_LIMIT = 400000;
	localparam logic [1:0]  KIND_NONE   = 2'd3;

	// how a row of the directed table is checked
	typedef enum logic [1:0] {
		CHECK_MODEL,
		CHECK_QUIET,
		CHECK_TYPED
	} check_t;

	typedef struct packed {
		in_item_t word;
		check_t   how;
		result_t  want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	wpd_stream_if #(.payload_t(in_item_t)) in_ch ();
	wpd_stream_if #(.payload_t(result_t))  out_ch ();

	wav_pcm_stream_decoder_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	result_t     expected_results [$];
	in_item_t    pending_words [$];
	stim_row_t   directed_rows [$];
	int unsigned mismatch_count = 0;
	int unsigned counted_words = 0;
	int unsigned cycle_count = 0;
	int unsigned holds_asked = 0;
	bit          steady = 1'b0;

	// decoder state mirrored by the predictor
	phase_t            dec_phase;
	longint unsigned   dec_count;
	logic [31:0]       dec_id;
	logic [31:0]       dec_len;
	logic [15:0]       dec_fmt_tag;
	logic [15:0]       dec_ext_tag;
	logic [15:0]       dec_chans;
	logic [31:0]       dec_rate;
	logic [15:0]       dec_bits;
	bit                dec_fmt_seen;
	logic [31:0]       dec_data_left;
	logic [7:0]        dec_frame [8];
	int unsigned       dec_frame_idx;

	// clock
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("wav_pcm_stream_decoder_top_tb: FAIL");
			$finish;
		end
	end

	function automatic result_t make_result(logic [1:0] rk, logic [15:0] l, logic [15:0] r,
			logic [1:0] ch, logic [15:0] rate, logic [5:0] bits, logic [1:0] err, logic done);
		result_t res;
		res.result_kind  = rk;
		res.left_sample  = l;
		res.right_sample = r;
		res.channels     = ch;
		res.sample_rate  = rate;
		res.sample_bits  = bits;
		res.error_code   = err;
		res.audio_done   = done;
		return res;
	endfunction

	function automatic void reset_decoder();
		dec_phase     = PH_IDLE;
		dec_count     = 0;
		dec_id        = '0;
		dec_len       = '0;
		dec_fmt_tag   = '0;
		dec_ext_tag   = '0;
		dec_chans     = '0;
		dec_rate      = '0;
		dec_bits      = '0;
		dec_fmt_seen  = 1'b0;
		dec_data_left = '0;
		dec_frame_idx = 0;
	endfunction

	task automatic enter_error(input logic [1:0] code, output bit has_res, output result_t res);
		dec_phase = PH_ERROR;
		has_res   = 1'b1;
		res       = make_result(RES_ERROR, '0, '0, '0, '0, '0, code, 1'b0);
	endtask

	// one channel sample of the current frame, widened or cut to 16 bits
	function automatic logic [15:0] pcm16(int unsigned base);
		case (dec_bits)
			16'd8:   return {dec_frame[base] - U8_OFFSET, 8'h00};
			16'd16:  return {dec_frame[base + 1], dec_frame[base]};
			16'd24:  return {dec_frame[base + 2], dec_frame[base + 1]};
			default: return {dec_frame[base + 3], dec_frame[base + 2]};
		endcase
	endfunction

	// end of the fmt body: pcm check, then skip of the remainder and pad
	task automatic leave_fmt(output bit has_res, output result_t res);
		longint unsigned take, rest;
		logic [15:0] tag;
		has_res = 1'b0;
		res     = '0;
		take = (dec_len < FMT_TAKE) ? dec_len : FMT_TAKE;
		tag  = dec_fmt_tag;
		if (tag == TAG_EXT && dec_len >= FMT_EXT_MIN) tag = dec_ext_tag;
		if (tag != TAG_PCM) begin
			enter_error(ERR_COMPRESSED, has_res, res);
		end else begin
			dec_fmt_seen = 1'b1;
			rest = longint'(dec_len) - take + dec_len[0];
			dec_count = rest;
			if (rest == 0) begin
				dec_phase = PH_CHUNK;
				dec_id    = '0;
				dec_len   = '0;
			end else begin
				dec_phase = PH_SKIP;
			end
		end
	endtask

	// predicts the result, if any, of one accepted input word
	task automatic decode_word(input in_item_t w, output bit has_res, output result_t res);
		int unsigned p, fsize;
		logic [7:0]  b;
		logic [15:0] l, r;
		bit          bits_ok, last;
		has_res = 1'b0;
		res     = '0;
		b       = w.byte_value;
		case (w.kind)
			KIND_START: begin
				reset_decoder();
				dec_phase = PH_HEADER;
			end
			KIND_END: begin
				case (dec_phase)
					PH_HEADER: enter_error(ERR_NOT_WAV, has_res, res);
					PH_CHUNK, PH_FMT, PH_SKIP: enter_error(ERR_NO_AUDIO, has_res, res);
					PH_DATA: begin
						dec_phase     = PH_DONE;
						dec_frame_idx = 0;
						has_res       = 1'b1;
						res = make_result(RES_EARLY_END, '0, '0, '0, '0, '0, '0, 1'b0);
					end
					default: ;
				endcase
			end
			KIND_BYTE: begin
				case (dec_phase)
					// riff tag, riff length, wave tag
					PH_HEADER: begin
						dec_id = {dec_id[23:0], b};
						dec_count++;
						if (dec_count == HDR_RIFF_LEN && dec_id != TAG_RIFF) begin
							enter_error(ERR_NOT_WAV, has_res, res);
						end else if (dec_count == HDR_LEN) begin
							if (dec_id != TAG_WAVE) begin
								enter_error(ERR_NOT_WAV, has_res, res);
							end else begin
								dec_phase = PH_CHUNK;
								dec_count = 0;
								dec_id    = '0;
								dec_len   = '0;
							end
						end
					end
					// chunk header: tag big-endian, length little-endian
					PH_CHUNK: begin
						p = int'(dec_count);
						if (p < 4) dec_id = {dec_id[23:0], b};
						else dec_len[8 * ((p - 4) % 4) +: 8] = dec_len[8 * ((p - 4) % 4) +: 8] | b;
						dec_count++;
						if (dec_count == CHUNK_HDR_LEN) begin
							dec_count = 0;
							if (dec_id == TAG_FMT) begin
								dec_fmt_tag = '0;
								dec_ext_tag = '0;
								dec_chans   = '0;
								dec_rate    = '0;
								dec_bits    = '0;
								dec_phase   = PH_FMT;
								if (dec_len == 0) leave_fmt(has_res, res);
							end else if (dec_id == TAG_DATA) begin
								bits_ok = dec_bits inside {16'd8, 16'd16, 16'd24, 16'd32};
								if (!dec_fmt_seen) begin
									enter_error(ERR_NO_AUDIO, has_res, res);
								end else if (dec_chans < 1 || dec_chans > 2 || dec_rate < RATE_MIN ||
										dec_rate > RATE_MAX || !bits_ok) begin
									enter_error(ERR_UNSUPPORTED, has_res, res);
								end else begin
									dec_data_left = dec_len;
									dec_frame_idx = 0;
									dec_phase     = (dec_len == 0) ? PH_DONE : PH_DATA;
									has_res       = 1'b1;
									res = make_result(RES_FORMAT, '0, '0, dec_chans[1:0], dec_rate[15:0],
										dec_bits[5:0], '0, dec_len == 0);
								end
							end else begin
								dec_count = longint'(dec_len) + dec_len[0];
								if (dec_count == 0) begin
									dec_id    = '0;
									dec_len   = '0;
									dec_phase = PH_CHUNK;
								end else begin
									dec_phase = PH_SKIP;
								end
							end
						end
					end
					// fmt body fields from the first bytes only
					PH_FMT: begin
						p = int'(dec_count);
						if (p == FMT_TAG_LO) dec_fmt_tag[7:0] = b;
						else if (p == FMT_TAG_HI) dec_fmt_tag[15:8] = b;
						else if (p == FMT_CHAN_LO) dec_chans[7:0] = b;
						else if (p == FMT_CHAN_HI) dec_chans[15:8] = b;
						else if (p >= FMT_RATE_0 && p <= FMT_RATE_3) dec_rate[8 * (p - 4) +: 8] = b;
						else if (p == FMT_BITS_LO) dec_bits[7:0] = b;
						else if (p == FMT_BITS_HI) dec_bits[15:8] = b;
						else if (p == FMT_EXT_LO) dec_ext_tag[7:0] = b;
						else if (p == FMT_EXT_HI) dec_ext_tag[15:8] = b;
						dec_count++;
						if (dec_count == ((dec_len < FMT_TAKE) ? dec_len : FMT_TAKE))
							leave_fmt(has_res, res);
					end
					PH_SKIP: begin
						dec_count--;
						if (dec_count == 0) begin
							dec_phase = PH_CHUNK;
							dec_id    = '0;
							dec_len   = '0;
						end
					end
					// audio bytes gathered into frames
					PH_DATA: begin
						fsize = dec_chans * (dec_bits / 8);
						dec_frame[dec_frame_idx % 8] = b;
						dec_data_left--;
						last = (dec_data_left == 0);
						if (dec_frame_idx + 1 < fsize) begin
							dec_frame_idx = (dec_frame_idx + 1) % 8;
							if (last) dec_phase = PH_DONE;
						end else begin
							dec_frame_idx = 0;
							l = pcm16(0);
							r = (dec_chans == 2) ? pcm16(dec_bits / 8) : l;
							if (last) dec_phase = PH_DONE;
							has_res = 1'b1;
							res = make_result(RES_FRAME, l, r, '0, '0, '0, '0, last);
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	// result side: compare every taken word with the oldest expectation
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing outstanding", got.result_kind, '0);
			end else begin
				want = expected_results.pop_front();
				compare_field("result_kind", got.result_kind, want.result_kind);
				compare_field("left_sample", got.left_sample, want.left_sample);
				compare_field("right_sample", got.right_sample, want.right_sample);
				compare_field("channels", got.channels, want.channels);
				compare_field("sample_rate", got.sample_rate, want.sample_rate);
				compare_field("sample_bits", got.sample_bits, want.sample_bits);
				compare_field("error_code", got.error_code, want.error_code);
				compare_field("audio_done", got.audio_done, want.audio_done);
			end
		end
	end

	// result side ready: random stalls, one long hold when asked
	initial begin : result_sink
		int held;
		int unsigned holds_served;
		holds_served = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				for (held = 0; held < LONG_HOLD; held++) begin
					out_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			out_ch.ready <= steady || ($urandom_range(99) >= 25);
		end
	end

	// offers one word, waits for it to be taken, then records what it should give
	task automatic drive_word(input in_item_t w, input check_t how, input result_t want);
		bit has_res;
		result_t res;
		while (!steady && $urandom_range(99) < 25) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= w;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (w.kind == KIND_START ||
				(w.kind inside {KIND_BYTE, KIND_END} && dec_phase inside {[PH_HEADER:PH_DATA]}))
			counted_words++;
		decode_word(w, has_res, res);
		case (how)
			CHECK_MODEL: if (has_res) expected_results.push_back(res);
			CHECK_TYPED: expected_results.push_back(want);
			default: ;
		endcase
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic stim_row_t stim_row(logic [1:0] k, logic [7:0] b, check_t how,
			logic [1:0] err);
		stim_row_t row;
		row.word.kind       = k;
		row.word.byte_value = b;
		row.how             = how;
		row.want = (how == CHECK_TYPED) ? make_result(RES_ERROR, '0, '0, '0, '0, '0, err, 1'b0) : '0;
		return row;
	endfunction

	// file building: words go to the pending queue, with stray ignored words now and then
	function automatic void put_word(logic [1:0] k, logic [7:0] b);
		in_item_t w;
		if ($urandom_range(59) == 0) begin
			w.kind       = KIND_NONE;
			w.byte_value = 8'($urandom);
			pending_words.push_back(w);
		end
		w.kind       = k;
		w.byte_value = b;
		pending_words.push_back(w);
	endfunction

	function automatic void put_tag(logic [31:0] t);
		int i;
		for (i = 3; i >= 0; i--) put_word(KIND_BYTE, t[8 * i +: 8]);
	endfunction

	function automatic void put_le32(logic [31:0] v);
		int i;
		for (i = 0; i < 4; i++) put_word(KIND_BYTE, v[8 * i +: 8]);
	endfunction

	// unknown chunk with a short body and its pad byte
	function automatic void put_filler_chunk();
		logic [31:0] len;
		int i;
		len = $urandom_range(0, 7);
		case ($urandom_range(3))
			0:       put_tag(32'h4C49_5354);
			1:       put_tag(32'h6661_6374);
			2:       put_tag(32'h6A75_6E6B);
			default: put_tag(32'h5045_414B);
		endcase
		put_le32(len);
		for (i = 0; i < len + len[0]; i++) put_word(KIND_BYTE, 8'($urandom));
	endfunction

	// fmt chunk, mostly plain pcm within the accepted range
	task automatic put_fmt_chunk(output logic [15:0] chans, output logic [15:0] bits);
		logic [7:0]  body [48];
		logic [31:0] flen, rate;
		logic [15:0] ftag, xtag;
		int unsigned pick;
		int i;
		case ($urandom_range(11))
			0, 1, 2, 3, 4: flen = 16;
			5:             flen = 18;
			6:             flen = 40;
			7:             flen = 41;
			8:             flen = 26;
			9:             flen = 25;
			10:            flen = $urandom_range(0, 15);
			default:       flen = 48;
		endcase
		pick = $urandom_range(99);
		xtag = 16'($urandom);
		if (pick < 84) ftag = TAG_PCM;
		else if (pick < 92) begin
			ftag = TAG_EXT;
			xtag = TAG_PCM;
			if (flen < FMT_EXT_MIN) flen = FMT_EXT_MIN + $urandom_range(0, 14);
		end else if (pick < 95) ftag = TAG_EXT;
		else ftag = 16'($urandom);
		if ($urandom_range(99) < 92) chans = $urandom_range(1, 2);
		else chans = $urandom_range(1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
		if ($urandom_range(99) < 86) begin
			case ($urandom_range(7))
				0:       rate = RATE_MIN;
				1:       rate = RATE_MAX;
				2:       rate = 32'd11025;
				3:       rate = 32'd22050;
				4:       rate = 32'd44100;
				default: rate = $urandom_range(RATE_MIN, RATE_MAX);
			endcase
		end else begin
			case ($urandom_range(3))
				0:       rate = RATE_MIN - 1;
				1:       rate = RATE_MAX + 1;
				2:       rate = $urandom_range(0, RATE_MIN - 1);
				default: rate = $urandom;
			endcase
		end
		if ($urandom_range(99) < 92) bits = 8 * $urandom_range(1, 4);
		else bits = $urandom_range(1) ? 16'($urandom_range(0, 40)) : 16'($urandom);
		for (i = 0; i < 48; i++) body[i] = 8'($urandom);
		body[FMT_TAG_LO]  = ftag[7:0];
		body[FMT_TAG_HI]  = ftag[15:8];
		body[FMT_CHAN_LO] = chans[7:0];
		body[FMT_CHAN_HI] = chans[15:8];
		body[FMT_RATE_0]  = rate[7:0];
		body[FMT_RATE_1]  = rate[15:8];
		body[FMT_RATE_2]  = rate[23:16];
		body[FMT_RATE_3]  = rate[31:24];
		body[FMT_BITS_LO] = bits[7:0];
		body[FMT_BITS_HI] = bits[15:8];
		body[FMT_EXT_LO]  = xtag[7:0];
		body[FMT_EXT_HI]  = xtag[15:8];
		put_tag(TAG_FMT);
		put_le32(flen);
		for (i = 0; i < flen; i++) put_word(KIND_BYTE, body[i]);
		if (flen[0]) put_word(KIND_BYTE, 8'($urandom));
	endtask

	// one whole file, mostly well formed, sometimes broken or cut short
	task automatic queue_wave_file();
		logic [15:0] chans, bits;
		logic [31:0] dlen, sent;
		int unsigned fsize, frames, cut;
		int i, fmt_count;
		chans = 16'd2;
		bits  = 16'd16;
		if ($urandom_range(19) == 0) put_word(KIND_BYTE, 8'($urandom));
		put_word(KIND_START, 8'($urandom));
		put_tag(($urandom_range(29) == 0) ? TAG_RIFF ^ (32'd1 << $urandom_range(31)) : TAG_RIFF);
		put_le32($urandom);
		put_tag(($urandom_range(29) == 0) ? TAG_WAVE ^ (32'd1 << $urandom_range(31)) : TAG_WAVE);
		if ($urandom_range(3) == 0) put_filler_chunk();
		case ($urandom_range(14))
			0:       fmt_count = 0;
			1, 2:    fmt_count = 2;
			default: fmt_count = 1;
		endcase
		for (i = 0; i < fmt_count; i++) put_fmt_chunk(chans, bits);
		if ($urandom_range(4) == 0) put_filler_chunk();
		// data chunk sized in frames, sometimes with a partial last frame
		fsize = chans * (bits / 8);
		if (fsize == 0 || fsize > 8) fsize = 4;
		frames = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		dlen = frames * fsize;
		if (fsize > 1 && $urandom_range(4) == 0) dlen += $urandom_range(1, fsize - 1);
		sent = dlen;
		case ($urandom_range(19))
			0:       dlen = $urandom | 32'h0001_0000;
			1, 2:    sent = dlen / 2;
			default: ;
		endcase
		put_tag(TAG_DATA);
		put_le32(dlen);
		for (i = 0; i < sent; i++) put_word(KIND_BYTE, 8'($urandom));
		if ($urandom_range(3) == 0) put_filler_chunk();
		if ($urandom_range(5) != 0) put_word(KIND_END, 8'($urandom));
		// cut anywhere and end there
		if ($urandom_range(11) == 0) begin
			cut = $urandom_range(1, pending_words.size() - 1);
			pending_words = pending_words[0:cut - 1];
			put_word(KIND_END, 8'($urandom));
		end
	endtask

	initial begin : stimulus
		int unsigned file_no;
		int i;
		in_ch.valid   <= 1'b0;
		in_ch.payload <= '0;
		arst_n        <= 1'b0;
		reset_decoder();
		file_no = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words: idle stream, tag errors, sticky error, early ends
		directed_rows = '{
			stim_row(KIND_BYTE,  8'hFF, CHECK_QUIET, '0),
			stim_row(KIND_END,   8'h00, CHECK_QUIET, '0),
			stim_row(KIND_NONE,  8'hA5, CHECK_QUIET, '0),
			stim_row(KIND_START, 8'hFF, CHECK_QUIET, '0),
			stim_row(KIND_BYTE,  8'h52, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h49, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h46, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h58, CHECK_TYPED, ERR_NOT_WAV),
			stim_row(KIND_BYTE,  8'h00, CHECK_QUIET, '0),
			stim_row(KIND_END,   8'hFF, CHECK_QUIET, '0),
			stim_row(KIND_START, 8'h00, CHECK_QUIET, '0),
			stim_row(KIND_END,   8'h00, CHECK_TYPED, ERR_NOT_WAV),
			stim_row(KIND_START, 8'h00, CHECK_QUIET, '0),
			stim_row(KIND_BYTE,  8'h52, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h49, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h46, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h46, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h00, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'hFF, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h00, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'hFF, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h57, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h41, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h56, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h45, CHECK_MODEL, '0),
			stim_row(KIND_BYTE,  8'h66, CHECK_MODEL, '0),
			stim_row(KIND_END,   8'hFF, CHECK_TYPED, ERR_NO_AUDIO)
		};
		for (i = 0; i < directed_rows.size(); i++)
			drive_word(directed_rows[i].word, directed_rows[i].how, directed_rows[i].want);

		// random files, with one long output hold, one drain and one stretch without gaps
		while (counted_words < WORD_TARGET) begin
			file_no++;
			steady = (file_no >= 15 && file_no < 20);
			if (file_no == 6) holds_asked++;
			queue_wave_file();
			while (pending_words.size() != 0)
				drive_word(pending_words.pop_front(), CHECK_MODEL, '0);
			if (file_no == 10) drain_results();
		end
		steady = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("wav_pcm_stream_decoder_top_tb: PASS");
		end else begin
			$display("wav_pcm_stream_decoder_top_tb: FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/wpd_pkg.sv
rtl/core/wpd_stream_if.sv
rtl/core/wpd_frame.sv
rtl/core/wpd_parser.sv
rtl/core/wav_pcm_stream_decoder_top.sv
tb/wav_pcm_stream_decoder_top_tb.sv
